[rtl/tkd_pkg.sv]
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared widths and key codes for the terminal key decoder.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 10;
  localparam int unsigned PosW  = 10;
  localparam int unsigned DimW  = 10;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [KeyW-1:0]  key_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [DimW-1:0]  dim_t;

  // Special key codes
  localparam key_t KeyPgUp = 10'd1000;
  localparam key_t KeyPgDn = 10'd1001;
  localparam key_t KeyHome = 10'd1002;
  localparam key_t KeyEnd  = 10'd1003;
  localparam key_t KeyDel  = 10'd1004;
  localparam key_t KeyQuit = 10'h011;
  localparam key_t KeyEsc  = 10'h01B;
  localparam key_t KeyLeft  = 10'h068; // h
  localparam key_t KeyDown  = 10'h06A; // j
  localparam key_t KeyUp    = 10'h06B; // k
  localparam key_t KeyRight = 10'h06C; // l

  // Sequence bytes
  localparam byte_t ChEsc     = 8'h1B;
  localparam byte_t ChBracket = 8'h5B; // [
  localparam byte_t ChO       = 8'h4F; // O
  localparam byte_t ChTilde   = 8'h7E; // ~
  localparam byte_t ChZero    = 8'h30;
  localparam byte_t ChNine    = 8'h39;

  // Screen size after reset
  localparam dim_t RowsReset = 10'd24;
  localparam dim_t ColsReset = 10'd80;

endpackage

[rtl/tkd_if.sv]
// ----------------------------------------------------------------------------
// tkd_in_if / tkd_out_if
// Valid/ready channels for input items and decoded keys.
// ----------------------------------------------------------------------------
interface tkd_in_if;
  import tkd_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  byte_t data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface tkd_out_if;
  import tkd_pkg::*;

  logic valid;
  logic ready;
  key_t key_value;
  pos_t cursor_col;
  pos_t cursor_row;
  logic quit;

  modport source (output valid, output key_value, output cursor_col,
                  output cursor_row, output quit, input ready);
  modport sink   (input valid, input key_value, input cursor_col,
                  input cursor_row, input quit, output ready);
endinterface

[rtl/terminal_key_decoder_cursor.sv]
// ----------------------------------------------------------------------------
// terminal_key_decoder_cursor
// VT100 escape sequence decoder that reports one key per plain byte or ended
// sequence and tracks a cursor clamped to the configured screen size.
// ----------------------------------------------------------------------------
//
//  port     | direction | handshake            | carries
//  ---------+-----------+----------------------+--------------------------------
//  in_i     | sink      | valid / ready        | func, data_byte
//  out_o    | source    | valid / ready        | key_value, cursor_col/row, quit
//  APB      | slave     | psel/penable, pready | screen_rows @0x0, screen_cols @0x4
//
// One item per cycle sustained while the result is not stalled. Each item is
// registered in the input register; the parser, cursor and result register
// then update from it, and its key appears on out_o from the result register.
// Reset clears the parser, the cursor and both valid flags; the screen size
// returns to 24 x 80. A stalled result holds the input register, and in_i
// stays ready as long as the input register can move on.
// ----------------------------------------------------------------------------
module terminal_key_decoder_cursor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tkd_in_if.sink                in_i,
  tkd_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tkd_pkg::*;

  localparam logic [2:0] AddrRows = 3'd0;
  localparam logic [2:0] AddrCols = 3'd4;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhEsc   = 2'd1;
  localparam logic [1:0] PhFirst = 2'd2;
  localparam logic [1:0] PhDigit = 2'd3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  dim_t rows_q, cols_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsReset;
      cols_q <= ColsReset;
    end else if (cfg_wr) begin
      if (paddr == AddrRows) rows_q <= pwdata[DimW-1:0];
      if (paddr == AddrCols) cols_q <= pwdata[DimW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == AddrRows) prdata = {{(32-DimW){1'b0}}, rows_q};
    if (paddr == AddrCols) prdata = {{(32-DimW){1'b0}}, cols_q};
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic  s1_valid_q;
  logic  s1_func_q;
  byte_t s1_byte_q;
  logic  out_free;
  logic  s1_adv;

  assign out_free   = !out_o.valid || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_func_q <= in_i.func;
      s1_byte_q <= in_i.data_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence parser
  // --------------------------------------------------------------------------
  function automatic key_t tilde_key(byte_t d);
    key_t k;
    unique case (d)
      8'h31, 8'h37: k = KeyHome;
      8'h33:        k = KeyDel;
      8'h34, 8'h38: k = KeyEnd;
      8'h35:        k = KeyPgUp;
      8'h36:        k = KeyPgDn;
      default:      k = KeyEsc;
    endcase
    return k;
  endfunction

  function automatic key_t pair_key(byte_t a, byte_t b);
    key_t k;
    k = KeyEsc;
    if (a == ChBracket) begin
      unique case (b)
        8'h41:   k = KeyUp;
        8'h42:   k = KeyDown;
        8'h43:   k = KeyRight;
        8'h44:   k = KeyLeft;
        8'h48:   k = KeyHome;
        8'h46:   k = KeyEnd;
        default: k = KeyEsc;
      endcase
    end else if (a == ChO) begin
      if (b == 8'h48) k = KeyHome;
      if (b == 8'h46) k = KeyEnd;
    end
    return k;
  endfunction

  logic [1:0] phase_q, phase_d;
  byte_t      first_q, first_d;
  byte_t      second_q, second_d;
  logic       emit;
  key_t       key;
  logic       is_digit;

  assign is_digit = (s1_byte_q >= ChZero) && (s1_byte_q <= ChNine);

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    emit     = 1'b0;
    key      = {{(KeyW-ByteW){1'b0}}, s1_byte_q};
    if (s1_adv) begin
      if (phase_q == PhIdle) begin
        if (!s1_func_q) begin
          if (s1_byte_q == ChEsc) begin
            phase_d = PhEsc;
          end else begin
            emit = 1'b1;
          end
        end
      end else if (s1_func_q) begin
        // timeout inside a sequence: report a bare ESC
        phase_d = PhIdle;
        emit    = 1'b1;
        key     = KeyEsc;
      end else begin
        unique case (phase_q)
          PhEsc: begin
            first_d = s1_byte_q;
            phase_d = PhFirst;
          end
          PhFirst: begin
            second_d = s1_byte_q;
            if (first_q == ChBracket && is_digit) begin
              phase_d = PhDigit;
            end else begin
              phase_d = PhIdle;
              emit    = 1'b1;
              key     = pair_key(first_q, s1_byte_q);
            end
          end
          default: begin
            phase_d = PhIdle;
            emit    = 1'b1;
            key     = (s1_byte_q == ChTilde) ? tilde_key(second_q) : KeyEsc;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  // --------------------------------------------------------------------------
  // Cursor
  // --------------------------------------------------------------------------
  dim_t rows_eff, cols_eff;
  pos_t col_q, col_d, row_q, row_d;

  assign rows_eff = (rows_q == '0) ? dim_t'(1) : rows_q;
  assign cols_eff = (cols_q == '0) ? dim_t'(1) : cols_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (emit) begin
      unique case (key)
        KeyLeft:  if (col_q != '0) col_d = col_q - pos_t'(1);
        KeyRight: if ({1'b0, col_q} + 11'd1 < {1'b0, cols_eff}) col_d = col_q + pos_t'(1);
        KeyUp:    if (row_q != '0) row_d = row_q - pos_t'(1);
        KeyDown:  if ({1'b0, row_q} + 11'd1 < {1'b0, rows_eff}) row_d = row_q + pos_t'(1);
        KeyHome:  col_d = '0;
        KeyEnd:   col_d = cols_eff - dim_t'(1);
        KeyPgUp:  row_d = '0;
        KeyPgDn:  row_d = rows_eff - dim_t'(1);
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic out_valid_q;
  key_t out_key_q;
  pos_t out_col_q, out_row_q;
  logic out_quit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_key_q  <= key;
      out_col_q  <= col_d;
      out_row_q  <= row_d;
      out_quit_q <= (key == KeyQuit);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.key_value  = out_key_q;
  assign out_o.cursor_col = out_col_q;
  assign out_o.cursor_row = out_row_q;
  assign out_o.quit       = out_quit_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_quit_matches_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_quit_q == (out_key_q == KeyQuit)))
    else $error("quit flag disagrees with key");

  a_digit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDigit) |-> (first_q == ChBracket &&
      second_q >= ChZero && second_q <= ChNine))
    else $error("digit phase without ESC [ digit");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("decoded key not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !emit)
    else $error("stalled result overwritten");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with empty input register");

endmodule

[bench/terminal_key_decoder_cursor_test.sv]
// ----------------------------------------------------------------------------
// terminal_key_decoder_cursor_test
// Self-checking bench for the VT100 key decoder and cursor tracker. A queue of
// bytes and timeouts feeds a random-gap driver. A local decoder model predicts
// each key and cursor position. A monitor with random stalls compares every
// result in order. The screen size is reprogrammed between phases.
// ----------------------------------------------------------------------------
module terminal_key_decoder_cursor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tkd_pkg::*;

  localparam int unsigned RegRows     = 0;
  localparam int unsigned RegCols     = 1;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned StallLimit  = 3000;

  typedef enum logic [1:0] {PhIdle, PhEsc, PhLead, PhDigit} parse_phase_e;

  typedef struct packed {
    logic  tmo;
    byte_t data;
  } rx_item_t;

  typedef struct packed {
    key_t key;
    pos_t col;
    pos_t row;
    logic quit;
  } key_result_t;

  logic clk = 1'b0;
  logic rst_ni;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tkd_in_if  in_if ();
  tkd_out_if out_if ();

  terminal_key_decoder_cursor dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  rx_item_t    rx_items [$];
  key_result_t want_keys [$];
  rx_item_t    next_rx;
  int unsigned items_queued;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned error_count;
  int unsigned idle_cycles;

  // Decoder model state
  dim_t         screen_rows = RowsReset;
  dim_t         screen_cols = ColsReset;
  parse_phase_e phase       = PhIdle;
  byte_t        seq_lead    = '0;
  byte_t        seq_digit   = '0;
  int unsigned  cur_col     = 0;
  int unsigned  cur_row     = 0;

  function automatic key_t tilde_key(input byte_t d);
    case (d)
      "1", "7": return KeyHome;
      "3":      return KeyDel;
      "4", "8": return KeyEnd;
      "5":      return KeyPgUp;
      "6":      return KeyPgDn;
      default:  return KeyEsc;
    endcase
  endfunction

  function automatic key_t csi_key(input byte_t lead, input byte_t fin);
    if (lead == ChBracket) begin
      case (fin)
        "A":     return KeyUp;
        "B":     return KeyDown;
        "C":     return KeyRight;
        "D":     return KeyLeft;
        "H":     return KeyHome;
        "F":     return KeyEnd;
        default: return KeyEsc;
      endcase
    end
    if (lead == ChO && fin == "H") return KeyHome;
    if (lead == ChO && fin == "F") return KeyEnd;
    return KeyEsc;
  endfunction

  // Move the cursor for one finished key and queue the result it produces
  task automatic post_key(input key_t key);
    int unsigned rows;
    int unsigned cols;
    key_result_t res;
    rows = (screen_rows == 0) ? 1 : screen_rows;
    cols = (screen_cols == 0) ? 1 : screen_cols;
    case (key)
      KeyLeft:  if (cur_col != 0) cur_col--;
      KeyRight: if (cur_col + 1 < cols) cur_col++;
      KeyUp:    if (cur_row != 0) cur_row--;
      KeyDown:  if (cur_row + 1 < rows) cur_row++;
      KeyHome:  cur_col = 0;
      KeyEnd:   cur_col = cols - 1;
      KeyPgUp:  cur_row = 0;
      KeyPgDn:  cur_row = rows - 1;
      default: ;
    endcase
    res.key  = key;
    res.col  = pos_t'(cur_col);
    res.row  = pos_t'(cur_row);
    res.quit = (key == KeyQuit);
    want_keys.push_back(res);
  endtask

  task automatic decode_rx(input rx_item_t it);
    if (phase == PhIdle) begin
      if (it.tmo) return;
      if (it.data == ChEsc) phase = PhEsc;
      else post_key(key_t'(it.data));
    end else if (it.tmo) begin
      phase = PhIdle;
      post_key(KeyEsc);
    end else if (phase == PhEsc) begin
      seq_lead = it.data;
      phase    = PhLead;
    end else if (phase == PhLead) begin
      seq_digit = it.data;
      if (seq_lead == ChBracket && it.data >= ChZero && it.data <= ChNine) begin
        phase = PhDigit;
      end else begin
        phase = PhIdle;
        post_key(csi_key(seq_lead, it.data));
      end
    end else begin
      phase = PhIdle;
      post_key(it.data == ChTilde ? tilde_key(seq_digit) : KeyEsc);
    end
  endtask

  // Driver: predict on each transfer, then load the next item or go idle
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        decode_rx('{tmo: in_if.func, data: in_if.data_byte});
      end
      if (!in_if.valid || in_if.ready) begin
        if (rx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_rx = rx_items.pop_front();
          in_if.valid     <= 1'b1;
          in_if.func      <= next_rx.tmo;
          in_if.data_byte <= next_rx.data;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (want_keys.size() == 0) begin
          error_count++;
          $display("%0t: unexpected key %0d col %0d row %0d quit %0b", $time,
                   out_if.key_value, out_if.cursor_col, out_if.cursor_row, out_if.quit);
        end else begin
          key_result_t exp_key;
          exp_key = want_keys.pop_front();
          if (out_if.key_value !== exp_key.key || out_if.cursor_col !== exp_key.col ||
              out_if.cursor_row !== exp_key.row || out_if.quit !== exp_key.quit) begin
            error_count++;
            $display({"%0t: expected key %0d col %0d row %0d quit %0b,",
                      " got key %0d col %0d row %0d quit %0b"},
                     $time, exp_key.key, exp_key.col, exp_key.row, exp_key.quit,
                     out_if.key_value, out_if.cursor_col, out_if.cursor_row, out_if.quit);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: count cycles with no transfer on any port
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_rx(input logic tmo, input byte_t data);
    rx_items.push_back('{tmo: tmo, data: data});
    items_queued++;
  endtask

  task automatic push_bytes(input string s);
    for (int i = 0; i < s.len(); i++) push_rx(1'b0, byte_t'(s[i]));
  endtask

  task automatic push_any_byte();
    push_rx(1'b0, byte_t'($urandom_range(255)));
  endtask

  // Random traffic: complete escape sequences are the largest share, with plain keys,
  // broken sequences and stray timeouts mixed in
  task automatic queue_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned extra;
    target = items_queued + count;
    while (items_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_rx(1'b0, ChEsc);
        case ($urandom_range(2))
          0: begin
            push_rx(1'b0, ChBracket);
            case ($urandom_range(5))
              0: push_bytes("A");
              1: push_bytes("B");
              2: push_bytes("C");
              3: push_bytes("D");
              4: push_bytes("H");
              default: push_bytes("F");
            endcase
          end
          1: begin
            push_rx(1'b0, ChO);
            push_bytes($urandom_range(1) ? "H" : "F");
          end
          default: begin
            push_rx(1'b0, ChBracket);
            push_rx(1'b0, byte_t'(ChZero + $urandom_range(9)));
            case ($urandom_range(9))
              0: push_any_byte();
              1: push_rx(1'b1, byte_t'($urandom_range(255)));
              default: push_rx(1'b0, ChTilde);
            endcase
          end
        endcase
      end else if (pick < 70) begin
        if ($urandom_range(1)) begin
          case ($urandom_range(4))
            0: push_bytes("h");
            1: push_bytes("j");
            2: push_bytes("k");
            3: push_bytes("l");
            default: push_rx(1'b0, byte_t'(KeyQuit));
          endcase
        end else begin
          push_any_byte();
        end
      end else if (pick < 90) begin
        push_rx(1'b0, ChEsc);
        extra = $urandom_range(3, 1);
        repeat (extra) begin
          case ($urandom_range(4))
            0: push_rx(1'b1, byte_t'($urandom_range(255)));
            1: push_rx(1'b0, ChBracket);
            2: push_rx(1'b0, ChO);
            default: push_any_byte();
          endcase
        end
      end else begin
        push_rx(1'b1, byte_t'($urandom_range(255)));
      end
    end
  endtask

  // Hold until every item is taken and every key has come out
  task automatic wait_drained();
    @(negedge clk);
    while (rx_items.size() != 0 || in_if.valid || want_keys.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic cfg_write(input int unsigned idx, input dim_t value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegRows) screen_rows = value;
    else screen_cols = value;
    @(negedge clk);
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.func      = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    items_queued    = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    error_count     = 0;
    idle_cycles     = 0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Directed: byte extremes, quit, timeouts in and out of a sequence,
    // each kind of sequence and an unmatched one
    push_rx(1'b0, 8'h00);
    push_rx(1'b0, 8'hFF);
    push_rx(1'b0, byte_t'(KeyQuit));
    push_rx(1'b1, 8'hAA);
    push_bytes("lj");
    push_rx(1'b0, ChEsc);
    push_rx(1'b1, 8'h55);
    push_rx(1'b0, ChEsc);
    push_bytes("[6~");
    push_rx(1'b0, ChEsc);
    push_bytes("[C");
    push_rx(1'b0, ChEsc);
    push_bytes("[4~");
    push_rx(1'b0, ChEsc);
    push_bytes("OH");
    push_rx(1'b0, ChEsc);
    push_bytes("[2X");
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      case (p)
        1: begin cfg_write(RegRows, 10'd999); cfg_write(RegCols, 10'd999); end
        2: begin cfg_write(RegRows, 10'd0);   cfg_write(RegCols, 10'd0);   end
        3: begin cfg_write(RegRows, 10'd3);   cfg_write(RegCols, 10'd5);   end
        4: begin cfg_write(RegRows, 10'd1);   cfg_write(RegCols, 10'd999); end
        5: begin
          cfg_write(RegRows, dim_t'($urandom_range(40, 1)));
          cfg_write(RegCols, dim_t'($urandom_range(40, 1)));
        end
        default: ;
      endcase
      queue_random(95);
      wait_drained();
      queue_random(95);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
